/* rtl/core/srcr_pkg.sv */
package srcr_pkg;

  // Fixed field widths of the step and smoothing paths.
  localparam int STEP_W = 27;
  localparam int COEF_W = 24;
  localparam int T_W    = 24;

  localparam logic [STEP_W-1:0] STEP_ONE   = 27'd16777216;
  localparam logic [STEP_W-1:0] STEP_MIN   = 27'd4194304;
  localparam logic [STEP_W-1:0] STEP_MAX   = 27'd67108864;
  localparam logic [COEF_W-1:0] COEF_RESET = 24'd1174;

  // Results per item are capped; a fresh stream waits two samples.
  localparam logic [4:0] MAX_OUT    = 5'd16;
  localparam logic [2:0] PEND_START = 3'd2;

  // Classified command that travels from the front to the back.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              start;
    logic              last;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

  // Back-end status seen at the top level.
  typedef struct packed {
    logic       idle;
    logic [4:0] n_emit;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_CALC,
    BK_EMIT,
    BK_FLUSH
  } back_state_t;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_DRAIN_A,
    PH_DRAIN_B
  } phase_t;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_M1,
    CU_M2,
    CU_M3,
    CU_DIV,
    CU_QUO,
    CU_FIX
  } cub_state_t;

endpackage

/* rtl/core/srcr_front.sv */
module srcr_front
  import srcr_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [STEP_W-1:0]             in_target_step,
  input  logic                          in_first_item,
  input  logic                          in_last_item,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [SAMPLE_BITS+CTL_W-1:0]  q_data
);

  logic              started_r;
  logic              started_nxt;
  logic              accept;
  logic [STEP_W-1:0] step_c;
  cmd_ctl_t          ctl;

  // A beat is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Clamp the wanted step to the supported range.
  always_comb begin
    if (in_target_step < STEP_MIN) begin
      step_c = STEP_MIN;
    end else if (in_target_step > STEP_MAX) begin
      step_c = STEP_MAX;
    end else begin
      step_c = in_target_step;
    end
  end

  // An item outside a running stream starts one.
  always_comb begin
    ctl.step  = step_c;
    ctl.start = in_first_item || !started_r;
    ctl.last  = in_last_item;
  end

  assign q_data = {in_sample_in, ctl};

  // The stream runs from its first beat until a last beat.
  assign started_nxt = accept ? !in_last_item : started_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

endmodule

/* rtl/core/srcr_queue.sv */
module srcr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid
);

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         wp_nxt;
  logic         rp_r;
  logic         rp_nxt;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = ent_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

/* rtl/core/srcr_cubic.sv */
module srcr_cubic
  import srcr_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] fm1,
  input  logic signed [SAMPLE_BITS-1:0] f0,
  input  logic signed [SAMPLE_BITS-1:0] f1,
  input  logic signed [SAMPLE_BITS-1:0] f2,
  input  logic [T_W-1:0]                t,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] y
);

  // Accumulator width covers the largest Horner intermediate.
  localparam int X    = SAMPLE_BITS + 6;
  localparam int K    = X + 2;
  localparam int MB_W = (X + 1 > T_W + 1) ? X + 1 : T_W + 1;
  localparam int P_W  = X + MB_W;

  localparam logic signed [MB_W-1:0] RECIP =
    MB_W'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic signed [P_W-1:0] RND_HALF = $signed({{(P_W-24){1'b0}}, 24'h800000});
  localparam logic signed [X-1:0]   DIV_BIAS = X'(3);
  localparam logic signed [X-1:0]   SIX      = X'(6);

  cub_state_t st_r;
  cub_state_t st_nxt;

  logic signed [X-1:0]           a_r;
  logic signed [X-1:0]           b_r;
  logic signed [X-1:0]           d_r;
  logic signed [SAMPLE_BITS-1:0] f0_r;
  logic [T_W-1:0]                t_r;
  logic signed [X-1:0]           acc_r;
  logic signed [P_W-1:0]         prod_r;
  logic signed [X-1:0]           q_r;
  logic signed [SAMPLE_BITS-1:0] y_r;

  logic signed [X-1:0]   em1;
  logic signed [X-1:0]   e0;
  logic signed [X-1:0]   e1;
  logic signed [X-1:0]   e2;
  logic signed [X-1:0]   bsum;
  logic signed [X-1:0]   a_c;
  logic signed [X-1:0]   b_c;
  logic signed [X-1:0]   d_c;
  logic                  sel_recip;
  logic                  sel_a;
  logic signed [X-1:0]   mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_p;
  logic signed [P_W-1:0] rnd_full;
  logic signed [X-1:0]   rnd;
  logic signed [P_W-1:0] quo_full;
  logic signed [X-1:0]   q6;
  logic signed [X-1:0]   rem;
  logic signed [X-1:0]   q_fix;
  logic signed [X-1:0]   ys;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // Polynomial coefficients from the window.
  always_comb begin
    em1  = X'(fm1);
    e0   = X'(f0);
    e1   = X'(f1);
    e2   = X'(f2);
    a_c  = e2 - em1 - (e1 + (e1 <<< 1)) + (e0 + (e0 <<< 1));
    bsum = e1 + em1 - (e0 <<< 1);
    b_c  = bsum + (bsum <<< 1);
    d_c  = e2 + (em1 <<< 1) - ((e1 <<< 2) + (e1 <<< 1)) + (e0 + (e0 <<< 1));
  end

  // Next-state logic of the evaluation sequencer.
  always_comb begin
    case (st_r)
      CU_IDLE: st_nxt = start ? CU_M1 : CU_IDLE;
      CU_M1:   st_nxt = CU_M2;
      CU_M2:   st_nxt = CU_M3;
      CU_M3:   st_nxt = CU_DIV;
      CU_DIV:  st_nxt = CU_QUO;
      CU_QUO:  st_nxt = CU_FIX;
      CU_FIX:  st_nxt = CU_IDLE;
      default: st_nxt = CU_IDLE;
    endcase
  end

  // Output and operand selection of the sequencer.
  always_comb begin
    done      = 1'b0;
    sel_recip = 1'b0;
    sel_a     = 1'b0;
    case (st_r)
      CU_M1:   sel_a     = 1'b1;
      CU_DIV:  sel_recip = 1'b1;
      CU_FIX:  done      = 1'b1;
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // Shared multiplier with half-up rounding by 2^24.
  assign mul_a    = sel_a ? a_r : acc_r;
  assign mul_b    = sel_recip ? RECIP : MB_W'(t_r);
  assign mul_p    = mul_a * mul_b;
  assign rnd_full = (mul_p + RND_HALF) >>> 24;
  assign rnd      = rnd_full[X-1:0];

  // Quotient correction and saturation.
  always_comb begin
    q6    = (q_r <<< 2) + (q_r <<< 1);
    rem   = acc_r - q6;
    q_fix = (rem >= SIX) ? q_r + X'(1) : q_r;
    ys    = X'(f0_r) + q_fix;
    if ((&ys[X-1:SAMPLE_BITS-1]) || !(|ys[X-1:SAMPLE_BITS-1])) begin
      y_sat = ys[SAMPLE_BITS-1:0];
    end else if (ys[X-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign quo_full = prod_r >>> K;
  assign y        = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CU_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath registers, one multiplication per cycle.
  always_ff @(posedge clk) begin
    case (st_r)
      CU_IDLE: begin
        if (start) begin
          a_r  <= a_c;
          b_r  <= b_c;
          d_r  <= d_c;
          f0_r <= f0;
          t_r  <= t;
        end
      end
      CU_M1:   acc_r  <= rnd + b_r;
      CU_M2:   acc_r  <= rnd - d_r;
      CU_M3:   acc_r  <= rnd + DIV_BIAS;
      CU_DIV:  prod_r <= mul_p;
      CU_QUO:  q_r    <= quo_full[X-1:0];
      CU_FIX:  y_r    <= y_sat;
      default: begin
        y_r <= y_r;
      end
    endcase
  end

endmodule

/* rtl/core/srcr_back.sv */
module srcr_back
  import srcr_pkg::*;
#(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [SAMPLE_BITS+CTL_W-1:0]  q_data,
  output logic                          q_pop,
  input  logic [COEF_W-1:0]             coef,
  output logic                          cu_start,
  output logic signed [SAMPLE_BITS-1:0] cu_fm1,
  output logic signed [SAMPLE_BITS-1:0] cu_f0,
  output logic signed [SAMPLE_BITS-1:0] cu_f1,
  output logic signed [SAMPLE_BITS-1:0] cu_f2,
  output logic [T_W-1:0]                cu_t,
  input  logic                          cu_done,
  input  logic signed [SAMPLE_BITS-1:0] cu_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_run_end,
  output bk_stat_t                      stat
);

  localparam int F      = FRACTION_BITS;
  localparam int POS_W  = F + 3;
  localparam int PROD_W = STEP_W + 1 + COEF_W + 1;
  localparam logic signed [PROD_W-1:0] SM_HALF = PROD_W'(25'sd8388608);

  back_state_t st_r;
  back_state_t st_nxt;

  logic signed [SAMPLE_BITS-1:0] win_r [4];
  logic [F-1:0]                  frac_r;
  logic [2:0]                    pend_r;
  logic [STEP_W-1:0]             smoothed_r;
  logic [STEP_W-1:0]             held_r;
  logic [4:0]                    n_r;
  phase_t                        phase_r;
  phase_t                        phase_nxt;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic                          last_r;
  logic signed [PROD_W-1:0]      sm_prod_r;
  logic signed [SAMPLE_BITS-1:0] hold_r;
  logic                          hold_vld_r;
  logic                          out_vld_r;
  logic signed [SAMPLE_BITS-1:0] out_smp_r;
  logic                          out_end_r;

  cmd_ctl_t                      q_ctl;
  logic signed [SAMPLE_BITS-1:0] q_smp;
  logic                          out_free;
  logic                          emit_ok;
  logic                          more_drain;
  logic                          do_shift;
  logic                          emit_go;
  logic                          push;
  logic                          push_end;
  logic                          flush_go;
  logic                          sm_upd;
  logic signed [STEP_W:0]        delta;
  logic signed [PROD_W-1:0]      sm_prod;
  logic signed [PROD_W-1:0]      sm_rnd_full;
  logic signed [STEP_W+1:0]      sm_sum;
  logic [POS_W-1:0]              stepf;
  logic [POS_W-1:0]              pos;
  logic [2:0]                    pend_dec;

  assign q_ctl = q_data[CTL_W-1:0];
  assign q_smp = q_data[SAMPLE_BITS+CTL_W-1:CTL_W];

  assign out_free = !out_vld_r || !out_stall;

  // Loop control: emit while the window is centred and the cap allows.
  always_comb begin
    emit_ok    = (pend_r == 3'd0) && (n_r != MAX_OUT) &&
                 !((phase_r == PH_DRAIN_B) && (frac_r != '0));
    more_drain = ((phase_r == PH_MAIN) && last_r) || (phase_r == PH_DRAIN_A);
    case (phase_r)
      PH_MAIN:    phase_nxt = PH_DRAIN_A;
      PH_DRAIN_A: phase_nxt = PH_DRAIN_B;
      default:    phase_nxt = PH_DRAIN_B;
    endcase
  end

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (q_valid) st_nxt = BK_CHECK;
      BK_CHECK: begin
        if (emit_ok) begin
          st_nxt = BK_CALC;
        end else if (!more_drain) begin
          st_nxt = BK_FLUSH;
        end
      end
      BK_CALC:  if (cu_done) st_nxt = BK_EMIT;
      BK_EMIT:  if (!hold_vld_r || out_free) st_nxt = BK_CHECK;
      BK_FLUSH: if (!hold_vld_r || out_free) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  // Per-state control outputs.
  always_comb begin
    q_pop    = 1'b0;
    cu_start = 1'b0;
    do_shift = 1'b0;
    emit_go  = 1'b0;
    push     = 1'b0;
    push_end = 1'b0;
    flush_go = 1'b0;
    sm_upd   = 1'b0;
    case (st_r)
      BK_IDLE:  q_pop = q_valid;
      BK_CHECK: begin
        cu_start = emit_ok;
        do_shift = !emit_ok && more_drain;
      end
      BK_CALC:  sm_upd = cu_done;
      BK_EMIT:  begin
        emit_go = !hold_vld_r || out_free;
        push    = hold_vld_r && out_free;
      end
      BK_FLUSH: begin
        flush_go = !hold_vld_r || out_free;
        push     = hold_vld_r && out_free;
        push_end = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // One-pole smoother: product registered, rounded add on completion.
  assign delta       = $signed({1'b0, held_r}) - $signed({1'b0, smoothed_r});
  assign sm_prod     = delta * $signed({1'b0, coef});
  assign sm_rnd_full = (sm_prod_r + SM_HALF) >>> 24;
  assign sm_sum      = $signed({2'b00, smoothed_r}) + sm_rnd_full[STEP_W+1:0];

  // Step scaled to the fraction width, and the advanced position.
  if (F >= 24) begin : g_wide
    assign stepf = POS_W'(smoothed_r) << (F - 24);
    assign cu_t  = frac_r[F-1 -: T_W];
  end else begin : g_narrow
    assign stepf = POS_W'(smoothed_r >> (24 - F));
    assign cu_t  = T_W'(frac_r) << (24 - F);
  end

  assign pos      = {3'b000, frac_r} + stepf;
  assign pend_dec = (pend_r != 3'd0) ? pend_r - 3'd1 : pend_r;

  assign cu_fm1 = win_r[0];
  assign cu_f0  = win_r[1];
  assign cu_f1  = win_r[2];
  assign cu_f2  = win_r[3];

  assign out_valid      = out_vld_r;
  assign out_sample_out = out_smp_r;
  assign out_run_end    = out_end_r;

  assign stat.idle   = (st_r == BK_IDLE);
  assign stat.n_emit = n_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= BK_IDLE;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      n_r        <= 5'd0;
      phase_r    <= PH_MAIN;
    end else begin
      st_r <= st_nxt;
      if (emit_go) begin
        hold_vld_r <= 1'b1;
      end else if (flush_go) begin
        hold_vld_r <= 1'b0;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (q_pop) begin
        n_r     <= 5'd0;
        phase_r <= PH_MAIN;
      end else begin
        if (emit_go) begin
          n_r <= n_r + 5'd1;
        end
        if (do_shift) begin
          phase_r <= phase_nxt;
        end
      end
    end
  end

  // Window, position and step registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s_r    <= q_smp;
      last_r <= q_ctl.last;
      held_r <= q_ctl.step;
      if (q_ctl.start) begin
        for (int i = 0; i < 4; i++) begin
          win_r[i] <= q_smp;
        end
        frac_r     <= '0;
        pend_r     <= PEND_START;
        smoothed_r <= q_ctl.step;
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= q_smp;
        pend_r   <= pend_dec;
      end
    end
    if (do_shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= s_r;
      pend_r   <= pend_dec;
    end
    if (cu_start) begin
      sm_prod_r <= sm_prod;
    end
    if (sm_upd) begin
      smoothed_r <= sm_sum[STEP_W-1:0];
    end
    if (emit_go) begin
      frac_r <= pos[F-1:0];
      pend_r <= pos[POS_W-1:F];
      hold_r <= cu_y;
    end
    if (push) begin
      out_smp_r <= hold_r;
      out_end_r <= push_end;
    end
  end

endmodule

/* rtl/core/smoothed_rate_cubic_resampler_top.sv */
// Variable-rate cubic resampler. Each input beat carries one audio sample and a
// wanted read step (unsigned Q3.24, clamped to 0.25..4); a one-pole smoother
// (cfg_wr_data, Q0.24) eases the step toward the latest target, and for every
// read position the four-sample window covers, one four-point cubic value
// comes out, saturated. Set first_item to open a stream; last_item drains the
// tail up to the final sample, and run_end marks the last result of each input
// beat (an item may give no result). An item gives up to 16 results, each from
// the interpolation unit, which runs three Horner products and a reciprocal
// division by six through one shared multiplier. A two-entry queue parts the
// input side from the evaluation back end, and the output register parts the
// back end from a stalled consumer. Write the coefficient only while the block
// is idle.
module smoothed_rate_cubic_resampler_top
  import srcr_pkg::*;
#(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [COEF_W-1:0]             cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [STEP_W-1:0]             in_target_step,
  input  logic                          in_first_item,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_run_end
);

  localparam int QW = SAMPLE_BITS + CTL_W;

  logic [COEF_W-1:0]             coef_r;
  logic [COEF_W-1:0]             coef_nxt;
  logic                          q_push;
  logic [QW-1:0]                 q_wdata;
  logic                          q_full;
  logic                          q_pop;
  logic [QW-1:0]                 q_rdata;
  logic                          q_valid;
  logic                          cu_start;
  logic signed [SAMPLE_BITS-1:0] cu_fm1;
  logic signed [SAMPLE_BITS-1:0] cu_f0;
  logic signed [SAMPLE_BITS-1:0] cu_f1;
  logic signed [SAMPLE_BITS-1:0] cu_f2;
  logic [T_W-1:0]                cu_t;
  logic                          cu_done;
  logic signed [SAMPLE_BITS-1:0] cu_y;
  bk_stat_t                      bk_stat;

  // Smoothing coefficient register.
  assign coef_nxt = cfg_wr_en ? cfg_wr_data : coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  srcr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_target_step (in_target_step),
    .in_first_item  (in_first_item),
    .in_last_item   (in_last_item),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  srcr_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  srcr_cubic #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cubic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cu_start),
    .fm1   (cu_fm1),
    .f0    (cu_f0),
    .f1    (cu_f1),
    .f2    (cu_f2),
    .t     (cu_t),
    .done  (cu_done),
    .y     (cu_y)
  );

  srcr_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .coef           (coef_r),
    .cu_start       (cu_start),
    .cu_fm1         (cu_fm1),
    .cu_f0          (cu_f0),
    .cu_f1          (cu_f1),
    .cu_f2          (cu_f2),
    .cu_t           (cu_t),
    .cu_done        (cu_done),
    .cu_y           (cu_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_run_end    (out_run_end),
    .stat           (bk_stat)
  );

  // The back end takes a command only from a non-empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A new command is taken only once the previous item has finished.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> bk_stat.idle)
    else $error("queue popped while an item is in progress");

  // The per-item result count never passes the cap.
  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.n_emit <= MAX_OUT)
    else $error("result count per item exceeded");

endmodule
